// ===== sv/erm_pkg.sv =====
// ----------------------------------------------------------------------------
// Extended Reinhard tone mapper package
// Shared op codes, field widths, constants and the queued command type.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int FIELD_W   = 32;
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_MEASURE = 2'd1;
    localparam logic [OP_W-1:0] OP_MAP     = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } t_cmd;

endpackage

// ===== sv/erm_in_if.sv =====
// ----------------------------------------------------------------------------
// Pixel command channel
// Valid/ready channel carrying the op code and the three HDR channels.
// ----------------------------------------------------------------------------
interface erm_in_if;
    import erm_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;

    modport source (output valid, op, red, green, blue, input ready);
    modport sink   (input valid, op, red, green, blue, output ready);
endinterface

// ===== sv/erm_out_if.sv =====
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel carrying one packed LDR pixel.
// ----------------------------------------------------------------------------
interface erm_out_if;
    import erm_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] pixel_word;

    modport source (output valid, pixel_word, input ready);
    modport sink   (input valid, pixel_word, output ready);
endinterface

// ===== sv/erm_front.sv =====
// ----------------------------------------------------------------------------
// Tone mapper front end
// Accepts commands, drops the unused op code and queues the rest in order.
// ----------------------------------------------------------------------------
module erm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    erm_in_if.sink        i_in,
    output erm_pkg::t_cmd o_head,
    output logic          o_head_valid,
    input  logic          i_pop
);
    import erm_pkg::*;

    t_cmd                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                push;
    logic                pop;
    t_cmd                cmd_in;

    assign i_in.ready   = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_queue[r_rd];

    assign cmd_in.op    = i_in.op;
    assign cmd_in.red   = i_in.red;
    assign cmd_in.green = i_in.green;
    assign cmd_in.blue  = i_in.blue;

    // The unused op code is accepted but never queued.
    assign push = i_in.valid && i_in.ready && (i_in.op != OP_NONE);
    assign pop  = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== sv/erm_back.sv =====
// ----------------------------------------------------------------------------
// Tone mapper back end
// Keeps the white point and maps pixels with one shared multiplier and a
// restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module erm_back #(
    parameter int FRAC_BITS    = 16,
    parameter int CHANNEL_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  erm_pkg::t_cmd i_head,
    input  logic          i_head_valid,
    output logic          o_pop,
    erm_out_if.source     o_out
);
    import erm_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int MX = (CB > FRAC_BITS) ? CB : FRAC_BITS;
    localparam int MW = MX + 1;          // multiplier operand width
    localparam int AW = MW + CB;         // W^2 + V*ONE
    localparam int DW = 2 * CB + MW;     // denominator
    localparam int NW = AW + CB + BYTE_W; // numerator

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_W2   = 4'd1;
    localparam logic [3:0] S_SUMA = 4'd2;
    localparam logic [3:0] S_A0   = 4'd3;
    localparam logic [3:0] S_A1   = 4'd4;
    localparam logic [3:0] S_D0   = 4'd5;
    localparam logic [3:0] S_D1   = 4'd6;
    localparam logic [3:0] S_SAT  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]        r_state;
    logic [CB-1:0]     r_wp;
    logic [CB-1:0]     r_w;
    logic [2*CB-1:0]   r_w2;
    logic [AW-1:0]     r_a;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_den;
    logic [CB-1:0]     r_ch [3];
    logic [1:0]        r_chan;
    logic [2:0]        r_bit;
    logic [BYTE_W-1:0] r_q;
    logic [BYTE_W-1:0] r_bytes [3];
    logic              r_out_valid;
    logic [FIELD_W-1:0] r_pixel;

    logic [CB-1:0]     v;
    logic [MW-1:0]     one_v;
    logic [MW-1:0]     mul_a;
    logic [MW-1:0]     mul_b;
    logic [2*MW-1:0]   prod;
    logic [NW-1:0]     den_sh;
    logic [NW-1:0]     den8;
    logic              div_hit;
    logic [BYTE_W-1:0] q_next;
    logic [CB-1:0]     hr, hg, hb, hmax;
    logic              out_free;

    assign o_pop       = (r_state == S_IDLE) && i_head_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.pixel_word = r_pixel;
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        case (r_chan)
            2'd0:    v = r_ch[0];
            2'd1:    v = r_ch[1];
            default: v = r_ch[2];
        endcase
    end

    assign one_v = (MW'(1) << FRAC_BITS) + MW'(v);

    always_comb begin
        case (r_state)
            S_W2: begin
                mul_a = MW'(r_w);
                mul_b = MW'(r_w);
            end
            S_A0: begin
                mul_a = MW'(r_a[CB-1:0]);
                mul_b = MW'(v);
            end
            S_A1: begin
                mul_a = r_a[AW-1:CB];
                mul_b = MW'(v);
            end
            S_D0: begin
                mul_a = MW'(r_w2[CB-1:0]);
                mul_b = one_v;
            end
            S_D1: begin
                mul_a = MW'(r_w2[2*CB-1:CB]);
                mul_b = one_v;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = (2*MW)'(mul_a) * (2*MW)'(mul_b);

    assign den_sh  = NW'(r_den) << r_bit;
    assign den8    = NW'(r_den) << BYTE_W;
    assign div_hit = (den_sh <= r_num);
    assign q_next  = div_hit ? (r_q | (BYTE_W'(1) << r_bit)) : r_q;

    assign hr   = i_head.red[CB-1:0];
    assign hg   = i_head.green[CB-1:0];
    assign hb   = i_head.blue[CB-1:0];
    always_comb begin
        hmax = hr;
        if (hg > hmax) begin
            hmax = hg;
        end
        if (hb > hmax) begin
            hmax = hb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
            r_chan      <= '0;
        end else begin
            // In S_DONE the valid flag is written by the state itself.
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head_valid) begin
                        case (i_head.op)
                            OP_CLEAR: begin
                                r_wp <= '0;
                            end
                            OP_MEASURE: begin
                                if (hmax > r_wp) begin
                                    r_wp <= hmax;
                                end
                            end
                            OP_MAP: begin
                                r_ch[0] <= hr;
                                r_ch[1] <= hg;
                                r_ch[2] <= hb;
                                r_w     <= r_wp;
                                r_chan  <= '0;
                                // A zero white point maps every channel to zero.
                                if (r_wp == '0) begin
                                    r_bytes[0] <= '0;
                                    r_bytes[1] <= '0;
                                    r_bytes[2] <= '0;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_state <= S_W2;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_W2: begin
                    r_w2    <= prod[2*CB-1:0];
                    r_state <= S_SUMA;
                end
                S_SUMA: begin
                    r_a     <= AW'(r_w2) + (AW'(v) << FRAC_BITS);
                    r_state <= S_A0;
                end
                S_A0: begin
                    r_num   <= NW'(prod);
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_num   <= r_num + (NW'(prod) << CB);
                    r_state <= S_D0;
                end
                S_D0: begin
                    r_num   <= (r_num << BYTE_W) - r_num;
                    r_den   <= DW'(prod);
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_den   <= r_den + (DW'(prod) << CB);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // A quotient of 256 or more saturates without dividing.
                    if (r_num >= den8) begin
                        r_bytes[r_chan] <= BYTE_MAX;
                        if (r_chan == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_chan  <= r_chan + 1'b1;
                            r_state <= S_SUMA;
                        end
                    end else begin
                        r_q     <= '0;
                        r_bit   <= 3'd7;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_hit) begin
                        r_num <= r_num - den_sh;
                    end
                    r_q   <= q_next;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 3'd0) begin
                        r_bytes[r_chan] <= q_next;
                        if (r_chan == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_chan  <= r_chan + 1'b1;
                            r_state <= S_SUMA;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_pixel     <= {BYTE_MAX, r_bytes[2], r_bytes[1], r_bytes[0]};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== sv/extended_reinhard_tone_mapper.sv =====
// ----------------------------------------------------------------------------
// Extended Reinhard tone mapper
// Tracks an HDR white point and maps Q16.16 pixels to packed 8-bit RGBA.
// ----------------------------------------------------------------------------
// Clear and measure commands complete in the back end's idle state; the time
// a map command takes is set by the single shared multiplier (four partial
// products per channel) and the divider that resolves one quotient bit per
// cycle, and a zero white point sends a map straight to the output state.
// A four-entry command queue lets the input run ahead, and the output
// register lets the next command start while a pixel waits to be taken.
module extended_reinhard_tone_mapper #(
    parameter int FRAC_BITS    = 16,
    parameter int CHANNEL_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    erm_in_if.sink    i_in,
    erm_out_if.source o_out
);
    import erm_pkg::*;

    t_cmd head;
    logic head_valid;
    logic pop;

    erm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    erm_back #(
        .FRAC_BITS    (FRAC_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Extended Reinhard tone mapper testbench
// Drives clear, measure and map commands with random gaps and back pressure,
// predicts each packed pixel with an exact integer model of the mapping and
// compares every result word in order.
// ----------------------------------------------------------------------------
module tb;
    import erm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_SHIFT = 16;
    localparam int SETTLE_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    erm_in_if  cmd_ch();
    erm_out_if pix_ch();

    extended_reinhard_tone_mapper DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (pix_ch.source)
    );

    always #2 i_clk = ~i_clk;

    logic [31:0] model_white;
    logic [31:0] expected_pixels[$];
    int          error_count = 0;
    bit          hold_output = 1'b0;
    int          hold_cycles = 0;
    int          out_idle = 0;
    int          out_draw;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.op    = OP_CLEAR;
        cmd_ch.red   = '0;
        cmd_ch.green = '0;
        cmd_ch.blue  = '0;
        pix_ch.ready = 1'b0;
    end

    function automatic logic [7:0] tone_byte(logic [31:0] v, logic [31:0] w);
        logic [255:0] w2;
        logic [255:0] num;
        logic [255:0] den;
        logic [7:0]   q;
        logic [7:0]   t;
        if (w == 0) return 8'd0;
        w2  = 256'(w) * 256'(w);
        num = (w2 + (256'(v) << ONE_SHIFT)) * 256'(v) * 256'd255;
        den = w2 * ((256'd1 << ONE_SHIFT) + 256'(v));
        q = 8'd0;
        for (int b = 7; b >= 0; b--) begin
            t = q | (8'd1 << b);
            if (den * 256'(t) <= num) q = t;
        end
        return q;
    endfunction

    task automatic predict_command(logic [1:0] op, logic [31:0] r, logic [31:0] g,
                                   logic [31:0] b);
        logic [31:0] peak;
        case (op)
            OP_CLEAR: model_white = '0;
            OP_MEASURE: begin
                peak = r;
                if (g > peak) peak = g;
                if (b > peak) peak = b;
                if (peak > model_white) model_white = peak;
            end
            OP_MAP: expected_pixels.push_back({BYTE_MAX, tone_byte(b, model_white),
                                               tone_byte(g, model_white),
                                               tone_byte(r, model_white)});
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Sends one transaction after a random gap and updates the prediction.
    // Valid stays high after acceptance; the next gap or a drain drops it.
    task automatic send_command(logic [1:0] op, logic [31:0] r, logic [31:0] g,
                                logic [31:0] b, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.red   <= r;
        cmd_ch.green <= g;
        cmd_ch.blue  <= b;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_command(op, r, g, b);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    function automatic logic [31:0] random_channel(logic [31:0] white);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0003_0000);
            2: return white;
            3: return (white == 0) ? 32'd0 : $urandom_range(0, white);
            4: return white + $urandom_range(0, 3);
            default: return 32'({8'($urandom_range(0, 255)), 8'h00}) << $urandom_range(0, 16);
        endcase
    endfunction

    // Result checker: a random wait before each pixel plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected pixel", pix_ch.pixel_word, '0);
            else if (pix_ch.pixel_word !== expected_pixels[0])
                report_mismatch("pixel_word", pix_ch.pixel_word, expected_pixels.pop_front());
            else
                void'(expected_pixels.pop_front());
        end
        if (hold_output) begin
            hold_cycles <= hold_cycles + 1;
            pix_ch.ready <= 1'b0;
        end else if (i_rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                out_draw = $urandom_range(0, 6);
                out_idle <= out_draw;
                pix_ch.ready <= (out_draw == 0);
            end else if (out_idle > 0) begin
                out_idle <= out_idle - 1;
                pix_ch.ready <= (out_idle == 1);
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_command(OP_MAP, 32'h0001_0000, '0, 32'hFFFF_FFFF);
        send_command(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(OP_MEASURE, 32'h0001_0000, 32'h0000_8000, 32'h0000_0001);
        send_command(OP_MAP, 32'h0001_0000, 32'h0000_8000, 32'h0000_0000);
        send_command(OP_MAP, 32'h0002_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        send_command(OP_MEASURE, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        send_command(OP_MAP, 32'h0000_0000, 32'h0000_FFFF, 32'h0001_0000);
        send_command(OP_MEASURE, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_command(OP_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000);
        send_command(OP_MAP, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA);
        send_command(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(OP_MAP, 32'h1234_5678, 32'h0, 32'h0001_0000);
        send_command(OP_MEASURE, 32'h0, 32'h0, 32'h0004_0000);
        send_command(OP_MAP, 32'h0004_0000, 32'h0002_0000, 32'h0000_4000);
        drain_results();
    endtask

    task automatic test_random_frames(int count);
        logic [1:0] op;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      op = OP_CLEAR;
            else if (pick == 1) op = OP_NONE;
            else if (pick < 6)  op = OP_MEASURE;
            else                op = OP_MAP;
            send_command(op, random_channel(model_white), random_channel(model_white),
                         random_channel(model_white));
        end
    endtask

    // Output held off while maps keep coming, so the command queue fills up.
    task automatic test_back_pressure();
        hold_output = 1'b1;
        fork
            begin
                for (int i = 0; i < 12; i++)
                    send_command(OP_MAP, $urandom(), random_channel(model_white),
                                 $urandom_range(0, 32'h0002_0000), 1'b1);
                cmd_ch.valid <= 1'b0;
            end
            begin
                wait (hold_cycles >= 400);
                hold_output = 1'b0;
            end
        join
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames(500);
        drain_results();
        test_back_pressure();
        test_random_frames(560);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/erm_pkg.sv
sv/erm_in_if.sv
sv/erm_out_if.sv
sv/erm_front.sv
sv/erm_back.sv
sv/extended_reinhard_tone_mapper.sv
tb/tb.sv
